@@ rtl/obot_pkg.sv @@
// ----------------------------------------------------------------------------
// obot_pkg
// Shared codes for the oriented box overlap test: query kinds and the
// configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package obot_pkg;

  // query kind carried with each input transaction
  typedef enum logic [1:0] {
    KindOverlap = 2'd0,
    KindPoint   = 2'd1,
    KindContain = 2'd2
  } obot_kind_e;

  // configuration register map
  typedef enum logic [2:0] {
    RegOriginX     = 3'd0,
    RegOriginY     = 3'd1,
    RegEdgeAX      = 3'd2,
    RegEdgeAY      = 3'd3,
    RegEdgeBX      = 3'd4,
    RegEdgeBY      = 3'd5,
    RegBoxEmpty    = 3'd6,
    RegAxisAligned = 3'd7
  } obot_reg_e;

  localparam int unsigned RegIndexBits = 3;

endpackage

`default_nettype wire

@@ rtl/oriented_box_overlap_test_unit.sv @@
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_unit
// Parallelogram versus axis-aligned box / point test: overlap, point
// containment and box containment, with separating-axis tests on both edge
// normals and a corner bounding box.
// ----------------------------------------------------------------------------
// Pipeline: stages one to five, then the output register, in that order.
// Throughput: one transaction per cycle while the output is not stalled; each
//   stage advances on its own, so bubbles collapse and input is taken while a
//   finished answer waits, as long as some stage is still empty.
// Reset: box registers take their reset values (origin and edges zero, empty
//   and aligned set), the derived box values clear and the pipeline empties.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_box_overlap_test_unit #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration write channel
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [obot_pkg::RegIndexBits-1:0]     cfg_index_i,
  input  wire logic [COORD_BITS:0]                   cfg_data_i,
  // query channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [1:0]                            kind_i,
  input  wire logic signed [COORD_BITS-1:0]          min_x_i,
  input  wire logic signed [COORD_BITS-1:0]          min_y_i,
  input  wire logic signed [COORD_BITS-1:0]          max_x_i,
  input  wire logic signed [COORD_BITS-1:0]          max_y_i,
  input  wire logic                                  query_empty_i,
  // answer channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       answer_o
);

  localparam int unsigned EW = COORD_BITS + 1;  // edge width
  localparam int unsigned DW = COORD_BITS + 1;  // point minus origin
  localparam int unsigned NW = COORD_BITS + 2;  // normal component
  localparam int unsigned PW = DW + NW;         // one product
  localparam int unsigned SW = PW + 1;          // projection
  localparam int unsigned GW = 2 * EW;          // edge cross product term
  localparam int unsigned RW = EW + 1;          // corner offset from origin
  localparam int unsigned BW = COORD_BITS + 3;  // bounding box coordinate

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [RW-1:0] min_rel(input logic signed [RW-1:0] a,
                                                   input logic signed [RW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [RW-1:0] max_rel(input logic signed [RW-1:0] a,
                                                   input logic signed [RW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] min_prj(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] max_prj(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic signed [EW-1:0]         edge_a_x_q, edge_a_y_q, edge_b_x_q, edge_b_y_q;
  logic                         box_empty_q, axis_aligned_q;
  logic                         cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      edge_a_x_q     <= '0;
      edge_a_y_q     <= '0;
      edge_b_x_q     <= '0;
      edge_b_y_q     <= '0;
      box_empty_q    <= 1'b1;
      axis_aligned_q <= 1'b1;
    end else if (cfg_we) begin
      case (obot_pkg::obot_reg_e'(cfg_index_i))
        obot_pkg::RegOriginX:     origin_x_q     <= cfg_data_i[COORD_BITS-1:0];
        obot_pkg::RegOriginY:     origin_y_q     <= cfg_data_i[COORD_BITS-1:0];
        obot_pkg::RegEdgeAX:      edge_a_x_q     <= cfg_data_i;
        obot_pkg::RegEdgeAY:      edge_a_y_q     <= cfg_data_i;
        obot_pkg::RegEdgeBX:      edge_b_x_q     <= cfg_data_i;
        obot_pkg::RegEdgeBY:      edge_b_y_q     <= cfg_data_i;
        obot_pkg::RegBoxEmpty:    box_empty_q    <= cfg_data_i[0];
        obot_pkg::RegAxisAligned: axis_aligned_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // derived box geometry, three free-running stages behind the registers
  // --------------------------------------------------------------------------
  logic signed [GW-1:0] g1_ab_q, g1_ab_d, g1_ba_q, g1_ba_d;
  logic signed [RW-1:0] g1_sum_x_q, g1_sum_x_d, g1_sum_y_q, g1_sum_y_d;
  logic signed [SW-1:0] g2_d0_q, g2_d0_d;
  logic signed [RW-1:0] g2_rminx_q, g2_rminx_d, g2_rmaxx_q, g2_rmaxx_d;
  logic signed [RW-1:0] g2_rminy_q, g2_rminy_d, g2_rmaxy_q, g2_rmaxy_d;
  logic signed [BW-1:0] bminx_q, bminx_d, bmaxx_q, bmaxx_d;
  logic signed [BW-1:0] bminy_q, bminy_d, bmaxy_q, bmaxy_d;
  logic signed [SW-1:0] lo_q [2];
  logic signed [SW-1:0] hi_q [2];
  logic signed [SW-1:0] lo_d [2];
  logic signed [SW-1:0] hi_d [2];

  // cross product terms and corner sum a+b
  always_comb begin
    g1_ab_d    = edge_a_x_q * edge_b_y_q;
    g1_ba_d    = edge_a_y_q * edge_b_x_q;
    g1_sum_x_d = RW'(edge_a_x_q) + RW'(edge_b_x_q);
    g1_sum_y_d = RW'(edge_a_y_q) + RW'(edge_b_y_q);
  end

  // span on normal a and corner extents relative to the origin
  always_comb begin
    g2_d0_d    = SW'(g1_ab_q) - SW'(g1_ba_q);
    g2_rminx_d = min_rel(min_rel('0, RW'(edge_a_x_q)), min_rel(RW'(edge_b_x_q), g1_sum_x_q));
    g2_rmaxx_d = max_rel(max_rel('0, RW'(edge_a_x_q)), max_rel(RW'(edge_b_x_q), g1_sum_x_q));
    g2_rminy_d = min_rel(min_rel('0, RW'(edge_a_y_q)), min_rel(RW'(edge_b_y_q), g1_sum_y_q));
    g2_rmaxy_d = max_rel(max_rel('0, RW'(edge_a_y_q)), max_rel(RW'(edge_b_y_q), g1_sum_y_q));
  end

  // absolute bounding box and both projection intervals (span on b is -d0)
  always_comb begin
    bminx_d = BW'(origin_x_q) + BW'(g2_rminx_q);
    bmaxx_d = BW'(origin_x_q) + BW'(g2_rmaxx_q);
    bminy_d = BW'(origin_y_q) + BW'(g2_rminy_q);
    bmaxy_d = BW'(origin_y_q) + BW'(g2_rmaxy_q);
    lo_d[0] = (g2_d0_q < 0) ? g2_d0_q : '0;
    hi_d[0] = (g2_d0_q > 0) ? g2_d0_q : '0;
    lo_d[1] = (g2_d0_q > 0) ? -g2_d0_q : '0;
    hi_d[1] = (g2_d0_q < 0) ? -g2_d0_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_ab_q    <= '0;
      g1_ba_q    <= '0;
      g1_sum_x_q <= '0;
      g1_sum_y_q <= '0;
      g2_d0_q    <= '0;
      g2_rminx_q <= '0;
      g2_rmaxx_q <= '0;
      g2_rminy_q <= '0;
      g2_rmaxy_q <= '0;
      bminx_q    <= '0;
      bmaxx_q    <= '0;
      bminy_q    <= '0;
      bmaxy_q    <= '0;
      lo_q[0]    <= '0;
      lo_q[1]    <= '0;
      hi_q[0]    <= '0;
      hi_q[1]    <= '0;
    end else begin
      g1_ab_q    <= g1_ab_d;
      g1_ba_q    <= g1_ba_d;
      g1_sum_x_q <= g1_sum_x_d;
      g1_sum_y_q <= g1_sum_y_d;
      g2_d0_q    <= g2_d0_d;
      g2_rminx_q <= g2_rminx_d;
      g2_rmaxx_q <= g2_rmaxx_d;
      g2_rminy_q <= g2_rminy_d;
      g2_rmaxy_q <= g2_rmaxy_d;
      bminx_q    <= bminx_d;
      bmaxx_q    <= bmaxx_d;
      bminy_q    <= bminy_d;
      bmaxy_q    <= bmaxy_d;
      lo_q[0]    <= lo_d[0];
      lo_q[1]    <= lo_d[1];
      hi_q[0]    <= hi_d[0];
      hi_q[1]    <= hi_d[1];
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: each stage moves when empty or when drained
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
  logic in_acc;

  assign rdy_out    = !out_v_q || !out_stall_i;
  assign rdy5       = !s5_v_q || rdy_out;
  assign rdy4       = !s4_v_q || rdy5;
  assign rdy3       = !s3_v_q || rdy4;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_acc     = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_q <= in_valid_i;
      end
      if (rdy2) begin
        s2_v_q <= s1_v_q;
      end
      if (rdy3) begin
        s3_v_q <= s2_v_q;
      end
      if (rdy4) begin
        s4_v_q <= s3_v_q;
      end
      if (rdy5) begin
        s5_v_q <= s4_v_q;
      end
      if (rdy_out) begin
        out_v_q <= s5_v_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: captured query
  // --------------------------------------------------------------------------
  obot_pkg::obot_kind_e         s1_kind_q;
  logic                         s1_qempty_q;
  logic signed [COORD_BITS-1:0] s1_x_q [2];
  logic signed [COORD_BITS-1:0] s1_y_q [2];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q   <= obot_pkg::obot_kind_e'(kind_i);
      s1_qempty_q <= query_empty_i;
      s1_x_q[0]   <= min_x_i;
      s1_x_q[1]   <= max_x_i;
      s1_y_q[0]   <= min_y_i;
      s1_y_q[1]   <= max_y_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: offsets from the origin and edge normals
  // --------------------------------------------------------------------------
  obot_pkg::obot_kind_e         s2_kind_q;
  logic                         s2_qempty_q;
  logic signed [COORD_BITS-1:0] s2_x_q [2];
  logic signed [COORD_BITS-1:0] s2_y_q [2];
  logic signed [DW-1:0]         s2_dx_q [2];
  logic signed [DW-1:0]         s2_dy_q [2];
  logic signed [DW-1:0]         s2_dx_d [2];
  logic signed [DW-1:0]         s2_dy_d [2];
  logic signed [NW-1:0]         s2_nx_q [2];
  logic signed [NW-1:0]         s2_ny_q [2];
  logic signed [NW-1:0]         s2_nx_d [2];
  logic signed [NW-1:0]         s2_ny_d [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      s2_dx_d[j] = DW'(s1_x_q[j]) - DW'(origin_x_q);
      s2_dy_d[j] = DW'(s1_y_q[j]) - DW'(origin_y_q);
    end
    s2_nx_d[0] = -NW'(edge_a_y_q);
    s2_ny_d[0] = NW'(edge_a_x_q);
    s2_nx_d[1] = -NW'(edge_b_y_q);
    s2_ny_d[1] = NW'(edge_b_x_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_kind_q   <= s1_kind_q;
      s2_qempty_q <= s1_qempty_q;
      for (int j = 0; j < 2; j++) begin
        s2_x_q[j]  <= s1_x_q[j];
        s2_y_q[j]  <= s1_y_q[j];
        s2_dx_q[j] <= s2_dx_d[j];
        s2_dy_q[j] <= s2_dy_d[j];
        s2_nx_q[j] <= s2_nx_d[j];
        s2_ny_q[j] <= s2_ny_d[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: products of offsets and normals
  // --------------------------------------------------------------------------
  obot_pkg::obot_kind_e         s3_kind_q;
  logic                         s3_qempty_q;
  logic signed [COORD_BITS-1:0] s3_x_q [2];
  logic signed [COORD_BITS-1:0] s3_y_q [2];
  logic signed [PW-1:0]         s3_mx_q [2][2];
  logic signed [PW-1:0]         s3_my_q [2][2];
  logic signed [PW-1:0]         s3_mx_d [2][2];
  logic signed [PW-1:0]         s3_my_d [2][2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        s3_mx_d[i][j] = s2_dx_q[j] * s2_nx_q[i];
        s3_my_d[i][j] = s2_dy_q[j] * s2_ny_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_kind_q   <= s2_kind_q;
      s3_qempty_q <= s2_qempty_q;
      for (int j = 0; j < 2; j++) begin
        s3_x_q[j] <= s2_x_q[j];
        s3_y_q[j] <= s2_y_q[j];
      end
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          s3_mx_q[i][j] <= s3_mx_d[i][j];
          s3_my_q[i][j] <= s3_my_d[i][j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: corner projections and bounding box tests
  // corners: 0 (min x, min y), 1 (max x, min y), 2 (min x, max y), 3 (max both)
  // --------------------------------------------------------------------------
  obot_pkg::obot_kind_e s4_kind_q;
  logic                 s4_qempty_q;
  logic signed [SW-1:0] s4_p_q [2][4];
  logic signed [SW-1:0] s4_p_d [2][4];
  logic                 s4_bbov_q, s4_bbov_d;
  logic [3:0]           s4_inbb_q, s4_inbb_d;
  logic signed [BW-1:0] qx [2];
  logic signed [BW-1:0] qy [2];
  logic [1:0]           inx, iny;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s4_p_d[i][0] = SW'(s3_mx_q[i][0]) + SW'(s3_my_q[i][0]);
      s4_p_d[i][1] = SW'(s3_mx_q[i][1]) + SW'(s3_my_q[i][0]);
      s4_p_d[i][2] = SW'(s3_mx_q[i][0]) + SW'(s3_my_q[i][1]);
      s4_p_d[i][3] = SW'(s3_mx_q[i][1]) + SW'(s3_my_q[i][1]);
    end
    for (int j = 0; j < 2; j++) begin
      qx[j]  = BW'(s3_x_q[j]);
      qy[j]  = BW'(s3_y_q[j]);
      inx[j] = (bminx_q <= qx[j]) && (qx[j] <= bmaxx_q);
      iny[j] = (bminy_q <= qy[j]) && (qy[j] <= bmaxy_q);
    end
    s4_inbb_d = {inx[1] && iny[1], inx[0] && iny[1], inx[1] && iny[0], inx[0] && iny[0]};
    s4_bbov_d = (qx[0] <= bmaxx_q) && (bminx_q <= qx[1]) &&
                (qy[0] <= bmaxy_q) && (bminy_q <= qy[1]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_kind_q   <= s3_kind_q;
      s4_qempty_q <= s3_qempty_q;
      s4_bbov_q   <= s4_bbov_d;
      s4_inbb_q   <= s4_inbb_d;
      for (int i = 0; i < 2; i++) begin
        for (int c = 0; c < 4; c++) begin
          s4_p_q[i][c] <= s4_p_d[i][c];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: projection extent of the query and per-corner interval checks
  // --------------------------------------------------------------------------
  obot_pkg::obot_kind_e s5_kind_q;
  logic                 s5_qempty_q;
  logic                 s5_bbov_q;
  logic [3:0]           s5_inbb_q;
  logic signed [SW-1:0] s5_pmin_q [2];
  logic signed [SW-1:0] s5_pmax_q [2];
  logic signed [SW-1:0] s5_pmin_d [2];
  logic signed [SW-1:0] s5_pmax_d [2];
  logic [3:0]           s5_in_q [2];
  logic [3:0]           s5_in_d [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s5_pmin_d[i] = min_prj(min_prj(s4_p_q[i][0], s4_p_q[i][1]),
                             min_prj(s4_p_q[i][2], s4_p_q[i][3]));
      s5_pmax_d[i] = max_prj(max_prj(s4_p_q[i][0], s4_p_q[i][1]),
                             max_prj(s4_p_q[i][2], s4_p_q[i][3]));
      for (int c = 0; c < 4; c++) begin
        s5_in_d[i][c] = (lo_q[i] <= s4_p_q[i][c]) && (s4_p_q[i][c] <= hi_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      s5_kind_q   <= s4_kind_q;
      s5_qempty_q <= s4_qempty_q;
      s5_bbov_q   <= s4_bbov_q;
      s5_inbb_q   <= s4_inbb_q;
      for (int i = 0; i < 2; i++) begin
        s5_pmin_q[i] <= s5_pmin_d[i];
        s5_pmax_q[i] <= s5_pmax_d[i];
        s5_in_q[i]   <= s5_in_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // answer select and output register
  // --------------------------------------------------------------------------
  logic       ov_norm, ans_d, answer_q;
  logic [3:0] has_pt;

  always_comb begin
    ov_norm = (s5_pmin_q[0] <= hi_q[0]) && (lo_q[0] <= s5_pmax_q[0]) &&
              (s5_pmin_q[1] <= hi_q[1]) && (lo_q[1] <= s5_pmax_q[1]);
    for (int c = 0; c < 4; c++) begin
      has_pt[c] = !box_empty_q &&
                  (axis_aligned_q ? s5_inbb_q[c] : (s5_in_q[0][c] && s5_in_q[1][c]));
    end
    case (s5_kind_q)
      obot_pkg::KindOverlap: ans_d = !box_empty_q && !s5_qempty_q && s5_bbov_q &&
                                     (axis_aligned_q || ov_norm);
      obot_pkg::KindPoint:   ans_d = has_pt[0];
      obot_pkg::KindContain: ans_d = s5_qempty_q || (&has_pt);
      default:               ans_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      answer_q <= ans_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign answer_o    = answer_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // an accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_v_q)
    else $error("accepted transaction missing from stage 1");

  // input is held back only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s2_v_q && s3_v_q && s4_v_q && s5_v_q && out_v_q))
    else $error("input stalled with an empty stage");

  // a finished answer behind a stalled output is kept
  a_last_stage_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v_q && out_v_q && out_stall_i |=> s5_v_q && out_v_q)
    else $error("transaction dropped behind stalled output");

  // projection intervals are ordered and mirror each other
  a_interval_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lo_q[0] <= hi_q[0]) && (lo_q[1] == -hi_q[0]) && (hi_q[1] == -lo_q[0]))
    else $error("projection interval inconsistent");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for oriented_box_overlap_test_unit. Box settings are
// loaded over the configuration channel while the unit is idle. Queries are
// sent as overlap, point and containment tests: first a short directed table,
// then random queries placed around the configured parallelogram, with noise
// mixed in. Every answer is compared in order against a typed table answer or
// an internal model of the separating-axis test. Both channels idle at random,
// and one long output hold fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW           = 24;
  localparam int NUM_REGS     = 8;
  localparam int PIPE_LATENCY = 5;
  localparam int HOLD_CYCLES  = 64;
  localparam int QUIET_LIMIT  = 2000;
  localparam int NUM_ROWS     = 25;

  localparam logic [1:0] KindUnused = 2'd3;

  localparam logic [CW-1:0] CMIN = 24'h800000;
  localparam logic [CW-1:0] CMAX = 24'h7FFFFF;
  localparam logic [CW:0]   EMIN = 25'h1000000;
  localparam logic [CW:0]   EMAX = 25'h0FFFFFF;
  localparam longint        LMIN = -64'sd8388608;
  localparam longint        LMAX = 64'sd8388607;

  // box settings used by the directed table
  localparam logic [2:0] SetReset       = 3'd0;
  localparam logic [2:0] SetDiamond     = 3'd1;
  localparam logic [2:0] SetDiamondBbox = 3'd2;
  localparam logic [2:0] SetSegment     = 3'd3;
  localparam logic [2:0] SetExtreme     = 3'd4;

  typedef struct packed {
    logic [2:0]    setting;
    logic [1:0]    kind;
    logic [CW-1:0] x0;
    logic [CW-1:0] y0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
    logic          qempty;
    logic          typed;
    logic          answer;
  } query_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready_o;
  obot_pkg::obot_reg_e  cfg_index;
  logic [CW:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall_o;
  logic [1:0]           kind;
  logic signed [CW-1:0] min_x;
  logic signed [CW-1:0] min_y;
  logic signed [CW-1:0] max_x;
  logic signed [CW-1:0] max_y;
  logic                 query_empty;
  logic                 out_valid_o;
  logic                 out_stall;
  logic                 answer_o;

  // answer of the query currently offered, and answers still owed by the unit
  logic offered_answer;
  logic popped_answer;
  logic pending_answers [$];

  logic hold_req = 1'b0;
  int   src_pct;
  int   sink_pct;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   queries_taken = 0;
  int   answers_checked = 0;
  int   true_answers = 0;
  int   settings_loaded = 0;

  // register image and the geometry derived from it
  logic [CW:0] box_reg [NUM_REGS];
  logic [CW:0] next_box [NUM_REGS];
  logic [CW:0] box_settings [5][NUM_REGS];
  query_row_t  directed_rows [NUM_ROWS];
  longint box_ox, box_oy, box_ax, box_ay, box_bx, box_by;
  longint norm_a_x, norm_a_y, norm_b_x, norm_b_y;
  longint span_a_lo, span_a_hi, span_b_lo, span_b_hi;
  longint bound_min_x, bound_max_x, bound_min_y, bound_max_y;
  bit     box_is_empty, box_is_aligned;

  oriented_box_overlap_test_unit #(
    .COORD_BITS(CW)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind),
    .min_x_i       (min_x),
    .min_y_i       (min_y),
    .max_x_i       (max_x),
    .max_y_i       (max_y),
    .query_empty_i (query_empty),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .answer_o      (answer_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] to_coord(longint v);
    if (v > LMAX) return CMAX;
    if (v < LMIN) return CMIN;
    return v[CW-1:0];
  endfunction

  // recompute normals, projection spans and bounding box from the registers
  function automatic void derive_box();
    longint d_a, d_b;
    box_ox = $signed(box_reg[obot_pkg::RegOriginX][CW-1:0]);
    box_oy = $signed(box_reg[obot_pkg::RegOriginY][CW-1:0]);
    box_ax = $signed(box_reg[obot_pkg::RegEdgeAX]);
    box_ay = $signed(box_reg[obot_pkg::RegEdgeAY]);
    box_bx = $signed(box_reg[obot_pkg::RegEdgeBX]);
    box_by = $signed(box_reg[obot_pkg::RegEdgeBY]);
    box_is_empty   = box_reg[obot_pkg::RegBoxEmpty][0];
    box_is_aligned = box_reg[obot_pkg::RegAxisAligned][0];
    norm_a_x = -box_ay;
    norm_a_y = box_ax;
    norm_b_x = -box_by;
    norm_b_y = box_bx;
    // corners relative to the origin are 0, a, b and a+b
    d_a = norm_a_x * box_bx + norm_a_y * box_by;
    d_b = norm_b_x * box_ax + norm_b_y * box_ay;
    span_a_lo = lmin(0, d_a);
    span_a_hi = lmax(0, d_a);
    span_b_lo = lmin(0, d_b);
    span_b_hi = lmax(0, d_b);
    bound_min_x = box_ox + lmin(lmin(0, box_ax), lmin(box_bx, box_ax + box_bx));
    bound_max_x = box_ox + lmax(lmax(0, box_ax), lmax(box_bx, box_ax + box_bx));
    bound_min_y = box_oy + lmin(lmin(0, box_ay), lmin(box_by, box_ay + box_by));
    bound_max_y = box_oy + lmax(lmax(0, box_ay), lmax(box_by, box_ay + box_by));
  endfunction

  function automatic longint project_onto(longint nx, longint ny, longint x, longint y);
    return (x - box_ox) * nx + (y - box_oy) * ny;
  endfunction

  function automatic bit box_holds_point(longint x, longint y);
    longint d;
    if (box_is_empty) return 1'b0;
    if (box_is_aligned) begin
      return bound_min_x <= x && x <= bound_max_x && bound_min_y <= y && y <= bound_max_y;
    end
    d = project_onto(norm_a_x, norm_a_y, x, y);
    if (d < span_a_lo || d > span_a_hi) return 1'b0;
    d = project_onto(norm_b_x, norm_b_y, x, y);
    return !(d < span_b_lo || d > span_b_hi);
  endfunction

  // expected answer of one query against the current box
  function automatic logic predict_answer(logic [1:0] k, logic signed [CW-1:0] x0,
                                          logic signed [CW-1:0] y0,
                                          logic signed [CW-1:0] x1,
                                          logic signed [CW-1:0] y1, logic qe);
    longint lx0, ly0, lx1, ly1, nx, ny, lo, hi, p0, p1, p2, p3;
    logic hit;
    lx0 = x0;
    ly0 = y0;
    lx1 = x1;
    ly1 = y1;
    hit = 1'b0;
    case (k)
      obot_pkg::KindOverlap: begin
        if (!box_is_empty && !qe && lx0 <= bound_max_x && bound_min_x <= lx1 &&
            ly0 <= bound_max_y && bound_min_y <= ly1) begin
          hit = 1'b1;
          if (!box_is_aligned) begin
            for (int i = 0; i < 2; i++) begin
              nx = (i == 0) ? norm_a_x : norm_b_x;
              ny = (i == 0) ? norm_a_y : norm_b_y;
              lo = (i == 0) ? span_a_lo : span_b_lo;
              hi = (i == 0) ? span_a_hi : span_b_hi;
              p0 = project_onto(nx, ny, lx0, ly0);
              p1 = project_onto(nx, ny, lx1, ly0);
              p2 = project_onto(nx, ny, lx0, ly1);
              p3 = project_onto(nx, ny, lx1, ly1);
              if (!(lmin(lmin(p0, p1), lmin(p2, p3)) <= hi &&
                    lo <= lmax(lmax(p0, p1), lmax(p2, p3)))) begin
                hit = 1'b0;
              end
            end
          end
        end
      end
      obot_pkg::KindPoint: hit = box_holds_point(lx0, ly0);
      obot_pkg::KindContain: begin
        hit = qe || (box_holds_point(lx0, ly0) && box_holds_point(lx1, ly0) &&
                     box_holds_point(lx0, ly1) && box_holds_point(lx1, ly1));
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // answer checking, expectation capture and the quiet-cycle count
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: answer %0b arrived with nothing expected", $time, answer_o);
          mismatches++;
        end else begin
          popped_answer = pending_answers.pop_front();
          if (popped_answer !== answer_o) begin
            $display("%0t: answer mismatch, expected %0b, got %0b", $time, popped_answer,
                     answer_o);
            mismatches++;
          end
          answers_checked++;
          if (answer_o === 1'b1) true_answers++;
        end
      end
      if (in_valid && !in_stall_o) begin
        pending_answers.push_back(offered_answer);
        queries_taken++;
      end
    end
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // answer receiver: random stalls, plus one long hold on request
  initial begin : answer_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(0, 99) < sink_pct);
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("oriented_box_overlap_test_unit test failed");
    $finish;
  end

  // stop offering and wait until every owed answer has come back
  task automatic drain_answers();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // write all registers from next_box once the unit is idle
  task automatic load_box();
    drain_answers();
    repeat (PIPE_LATENCY) @(posedge clk);
    for (int r = 0; r < NUM_REGS; r++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = obot_pkg::obot_reg_e'(r);
      cfg_data  = next_box[r];
      do @(posedge clk); while (!cfg_ready_o);
      box_reg[r] = next_box[r];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
    derive_box();
    settings_loaded++;
  endtask

  task automatic load_random_box(bit wide);
    int          v;
    logic [31:0] raw;
    for (int r = 0; r < NUM_REGS; r++) begin
      raw = $urandom;
      if (!wide) begin
        v   = $urandom_range(0, 6000) - 3000;
        raw = v;
      end
      next_box[r] = raw[CW:0];
    end
    // occasionally a true rectangle
    if (!wide && $urandom_range(0, 99) < 20) begin
      next_box[obot_pkg::RegEdgeAY] = '0;
      next_box[obot_pkg::RegEdgeBX] = '0;
    end
    raw = $urandom;
    raw[0] = ($urandom_range(0, 99) < 15);
    next_box[obot_pkg::RegBoxEmpty] = raw[CW:0];
    raw = $urandom;
    raw[0] = ($urandom_range(0, 99) < 25);
    next_box[obot_pkg::RegAxisAligned] = raw[CW:0];
    load_box();
  endtask

  // offer one query and hold it until the unit takes it
  task automatic send_query(logic [1:0] k, logic signed [CW-1:0] x0,
                            logic signed [CW-1:0] y0, logic signed [CW-1:0] x1,
                            logic signed [CW-1:0] y1, logic qe, logic want);
    while ($urandom_range(0, 99) < src_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid       = 1'b1;
    kind           = k;
    min_x          = x0;
    min_y          = y0;
    max_x          = x1;
    max_y          = y1;
    query_empty    = qe;
    offered_answer = want;
    do @(posedge clk); while (in_stall_o);
  endtask

  // query placed around the box, corners hit now and then, some pure noise
  task automatic send_random_query(bit wide);
    int                   pick, u, v, span;
    longint               cx, cy;
    logic [1:0]           k;
    logic signed [CW-1:0] x0, y0, x1, y1, tmp;
    logic                 qe;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      k  = 2'($urandom);
      x0 = CW'($urandom);
      y0 = CW'($urandom);
      x1 = CW'($urandom);
      y1 = CW'($urandom);
      qe = 1'($urandom);
    end else begin
      v = $urandom_range(0, 99);
      k = (v < 40) ? obot_pkg::KindOverlap : (v < 70) ? obot_pkg::KindPoint :
          (v < 97) ? obot_pkg::KindContain : KindUnused;
      if (pick < 25) begin
        u    = 8 * $urandom_range(0, 1);
        v    = 8 * $urandom_range(0, 1);
        span = 2;
      end else begin
        u    = $urandom_range(0, 16) - 4;
        v    = $urandom_range(0, 16) - 4;
        span = wide ? 4000000 : 1200;
      end
      cx = box_ox + (box_ax * u + box_bx * v) / 8;
      cy = box_oy + (box_ay * u + box_by * v) / 8;
      x0 = to_coord(cx - longint'($urandom_range(0, span)));
      y0 = to_coord(cy - longint'($urandom_range(0, span)));
      x1 = to_coord(cx + longint'($urandom_range(0, span)));
      y1 = to_coord(cy + longint'($urandom_range(0, span)));
      if ($urandom_range(0, 99) < 5) begin
        tmp = x0;
        x0  = x1;
        x1  = tmp;
      end
      qe = ($urandom_range(0, 99) < 10);
    end
    send_query(k, x0, y0, x1, y1, qe, predict_answer(k, x0, y0, x1, y1, qe));
  endtask

  initial begin : stimulus
    query_row_t row;
    logic       want;
    logic [2:0] active_setting;

    // origin x/y, edge a x/y, edge b x/y, empty, aligned
    box_settings = '{
      '{25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'd1, 25'd1},
      '{-25'sd1000, 25'sd0, 25'sd1000, 25'sd1000, 25'sd1000, -25'sd1000, 25'd0, 25'd0},
      '{-25'sd1000, 25'sd0, 25'sd1000, 25'sd1000, 25'sd1000, -25'sd1000, 25'd0, 25'd1},
      '{25'sd0, 25'sd0, 25'sd2000, 25'sd0, 25'sd0, 25'sd0, 25'd0, 25'd0},
      '{{1'b1, CMIN}, {1'b0, CMAX}, EMAX, EMIN, EMIN, EMAX, 25'd0, 25'd0}
    };

    // setting, kind, x0, y0, x1, y1, query empty, typed, answer
    directed_rows = '{
      '{SetReset, obot_pkg::KindOverlap, CMIN, CMIN, CMAX, CMAX, 1'b0, 1'b1, 1'b0},
      '{SetReset, obot_pkg::KindPoint, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1,
        1'b0},
      '{SetReset, obot_pkg::KindContain, CMIN, CMIN, CMAX, CMAX, 1'b1, 1'b1, 1'b1},
      '{SetReset, obot_pkg::KindContain, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1,
        1'b0},
      '{SetReset, KindUnused, CMAX, CMAX, CMIN, CMIN, 1'b1, 1'b1, 1'b0},
      '{SetDiamond, obot_pkg::KindPoint, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0,
        1'b0},
      '{SetDiamond, obot_pkg::KindPoint, -24'sd1000, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0,
        1'b0},
      '{SetDiamond, obot_pkg::KindPoint, 24'sd600, 24'sd600, 24'sd0, 24'sd0, 1'b0, 1'b0,
        1'b0},
      '{SetDiamond, obot_pkg::KindOverlap, 24'sd500, 24'sd500, 24'sd900, 24'sd900,
        1'b0, 1'b0, 1'b0},
      '{SetDiamond, obot_pkg::KindOverlap, -24'sd100, -24'sd100, 24'sd100, 24'sd100,
        1'b0, 1'b0, 1'b0},
      '{SetDiamond, obot_pkg::KindContain, -24'sd100, -24'sd100, 24'sd100, 24'sd100,
        1'b0, 1'b0, 1'b0},
      '{SetDiamond, obot_pkg::KindContain, -24'sd900, -24'sd900, 24'sd900, 24'sd900,
        1'b0, 1'b0, 1'b0},
      '{SetDiamond, obot_pkg::KindOverlap, 24'sd100, 24'sd100, -24'sd100, -24'sd100,
        1'b0, 1'b0, 1'b0},
      '{SetDiamond, obot_pkg::KindOverlap, -24'sd100, -24'sd100, 24'sd100, 24'sd100,
        1'b1, 1'b1, 1'b0},
      '{SetDiamond, obot_pkg::KindContain, CMAX, CMAX, CMIN, CMIN, 1'b1, 1'b1, 1'b1},
      '{SetDiamond, KindUnused, -24'sd100, -24'sd100, 24'sd100, 24'sd100, 1'b0, 1'b1,
        1'b0},
      '{SetDiamondBbox, obot_pkg::KindPoint, 24'sd600, 24'sd600, 24'sd0, 24'sd0, 1'b0,
        1'b0, 1'b0},
      '{SetDiamondBbox, obot_pkg::KindOverlap, 24'sd500, 24'sd500, 24'sd900, 24'sd900,
        1'b0, 1'b0, 1'b0},
      '{SetSegment, obot_pkg::KindPoint, 24'sd1000, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0,
        1'b0},
      '{SetSegment, obot_pkg::KindPoint, 24'sd1000, 24'sd5, 24'sd0, 24'sd0, 1'b0, 1'b0,
        1'b0},
      '{SetSegment, obot_pkg::KindOverlap, -24'sd10, -24'sd10, 24'sd10, 24'sd10, 1'b0,
        1'b0, 1'b0},
      '{SetExtreme, obot_pkg::KindPoint, CMIN, CMAX, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b0},
      '{SetExtreme, obot_pkg::KindOverlap, CMIN, CMIN, CMAX, CMAX, 1'b0, 1'b0, 1'b0},
      '{SetExtreme, obot_pkg::KindContain, CMIN, CMIN, CMAX, CMAX, 1'b0, 1'b0, 1'b0},
      '{SetExtreme, obot_pkg::KindPoint, CMAX, CMIN, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b0}
    };

    // every input known from time zero, with reset asserted first
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = obot_pkg::RegOriginX;
    cfg_data       = '0;
    in_valid       = 1'b0;
    kind           = obot_pkg::KindOverlap;
    min_x          = '0;
    min_y          = '0;
    max_x          = '0;
    max_y          = '0;
    query_empty    = 1'b0;
    offered_answer = 1'b0;
    src_pct        = 30;
    sink_pct       = 63;
    for (int r = 0; r < NUM_REGS; r++) box_reg[r] = box_settings[SetReset][r];
    derive_box();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    active_setting = SetReset;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = directed_rows[i];
      if (row.setting != active_setting) begin
        for (int r = 0; r < NUM_REGS; r++) next_box[r] = box_settings[row.setting][r];
        load_box();
        active_setting = row.setting;
      end
      want = row.typed ? row.answer :
             predict_answer(row.kind, row.x0, row.y0, row.x1, row.y1, row.qempty);
      send_query(row.kind, row.x0, row.y0, row.x1, row.y1, row.qempty, want);
    end

    // random phases: receiver idles more, then sender idles more, then no idling
    for (int m = 0; m < 3; m++) begin
      src_pct  = (m == 0) ? 30 : (m == 1) ? 63 : 0;
      sink_pct = (m == 0) ? 63 : (m == 1) ? 30 : 0;
      for (int p = 0; p < 4; p++) begin
        load_random_box(p == 3);
        for (int n = 0; n < 90; n++) begin
          if (m == 0 && p == 0 && n == 20) hold_req = 1'b1;
          if (n == 45) drain_answers();
          send_random_query(p == 3);
        end
      end
    end

    drain_answers();
    repeat (4 * PIPE_LATENCY) @(posedge clk);

    $display("%0d queries, %0d answers checked (%0d true) over %0d box settings",
             queries_taken, answers_checked, true_answers, settings_loaded);
    $display("included empty, aligned, degenerate and extreme boxes, inverted and empty "
             , "queries, a long output hold and drained pauses");
    if (mismatches == 0) begin
      $display("oriented_box_overlap_test_unit test passed");
    end else begin
      $display("oriented_box_overlap_test_unit test failed");
    end
    $finish;
  end

endmodule
